### design/priority_state_store_top_assert.svh
// Assertion macros for the priority state store.
// Used by the top level; no other dependencies.
`ifndef PRIORITY_STATE_STORE_TOP_ASSERT_SVH
`define PRIORITY_STATE_STORE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSS_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`else
`define PSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSS_ASSERT_IMP(lbl, clk, rst_n, a, b, msg)
`endif
`endif

### design/pss_pkg.sv
// Types and constants for the priority state store.
// No dependencies.
`timescale 1ns / 1ps
package pss_pkg;
  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_FIND  = 3'd1;
  localparam logic [2:0] FUNC_FREEM = 3'd2;
  localparam logic [2:0] FUNC_FREEL = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NONE  = 3'd1;
  localparam logic [2:0] ST_AMBIG = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  localparam logic [15:0] LOCAL_PRIORITY = 16'hFFFF;
  localparam logic [15:0] MEM_RESET      = 16'd2048;
  localparam int          ID_BITS        = 160;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] id_hi;
    logic [63:0] id_mid;
    logic [31:0] id_lo;
    logic [4:0]  id_len;
    logic [15:0] state_size;
    logic [15:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  match_count;
    logic [3:0]  match_slot;
    logic [15:0] memory_left;
    logic [2:0]  status;
  } out_word_t;

  // one stored entry
  typedef struct packed {
    logic [ID_BITS-1:0] key;
    logic [15:0]        bytes;
    logic [15:0]        retention;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               load;    // store the new entry in the append cell
    logic               shift;   // take the right neighbour's entry
    logic               rot;     // circulate the ring one place
  } cell_ctl_t;
endpackage

### design/priority_state_store_top.sv
// Top level of the priority state store: control and a ring of entry cells.
// Depends on pss_pkg, pss_cell and priority_state_store_top_assert.svh.
//
//  channel | dir | handshake      | payload
//  in      | in  | in_valid/ready | in_word_t
//  out     | out | out_valid/ready| out_word_t
//  cfg     | in  | cfg_we         | memory_total, 16 bits
//
// A find or free is offered as a result after the scan and the DONE state:
// the entries circulate once through cell 0, where one comparator scans them,
// then the DONE state compacts the chain. Add, clear and unused codes go
// straight to the DONE state. Reset empties the table and sets memory to 2048.
// A result waits in an output register and holds off input; the next word is
// taken at the earliest in the cycle after the result word leaves.
`timescale 1ns / 1ps
`include "priority_state_store_top_assert.svh"
module priority_state_store_top
  import pss_pkg::*;
#(
  parameter int MAX_STATES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data_o,
  input  logic      cfg_we,
  input  logic [15:0] cfg_data_i
);
  localparam int IW = $clog2(MAX_STATES);
  localparam int CW = $clog2(MAX_STATES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_q, state_d;
  in_word_t      req_q;
  logic [CW-1:0] cnt_q;
  logic [15:0]   mem_tot_q, left_q;
  logic [IW:0]   idx_q;
  logic [CW-1:0] mc_q;
  logic [IW-1:0] ms_q, low_q, loc_q;
  logic [15:0]   lowp_q;
  logic          loc_f_q;
  out_word_t     res_q;
  logic          ov_q;

  entry_t    ent [MAX_STATES];
  cell_ctl_t ctl;
  entry_t    new_e;
  logic [IW-1:0] free_slot;
  logic      do_free;

  // build the ring of cells
  for (genvar g = 0; g < MAX_STATES; g++) begin : g_cell
    pss_cell u_cell (
      .clk_i,
      .ctl_i     (ctl),
      .is_tail_i (CW'(g) == cnt_q),
      .shift_en_i(IW'(g) >= free_slot),
      .new_i     (new_e),
      .next_i    (ent[(g + 1) % MAX_STATES]),
      .ent_o     (ent[g])
    );
  end

  assign new_e = '{key: {req_q.id_hi, req_q.id_mid, req_q.id_lo},
                   bytes: req_q.state_size, retention: req_q.priority_req};

  // prefix compare on cell 0
  logic [4:0]       len_c;
  logic [ID_BITS-1:0] mask, pre;
  logic             hit, in_use;
  always_comb begin
    len_c = req_q.id_len < 5'd6 ? 5'd6 : (req_q.id_len > 5'd20 ? 5'd20 : req_q.id_len);
    mask  = ~({ID_BITS{1'b1}} >> {len_c, 3'b000});
    pre   = {req_q.id_hi, req_q.id_mid, req_q.id_lo};
    hit   = ((ent[0].key ^ pre) & mask) == '0;
    in_use = CW'(idx_q) < cnt_q;
  end

  assign in_ready = (state_q == S_IDLE) && !ov_q;
  wire scanning = state_q == S_SCAN;
  wire last = idx_q == (IW + 1)'(MAX_STATES - 1);
  wire is_add = req_q.func == FUNC_ADD;
  wire add_ok = is_add && cnt_q < CW'(MAX_STATES) && req_q.state_size <= left_q;

  always_comb begin
    free_slot = '0;
    do_free   = 1'b0;
    if (state_q == S_DONE) begin
      if (req_q.func == FUNC_FREEM && mc_q == CW'(1)) begin
        do_free = 1'b1; free_slot = ms_q;
      end else if (req_q.func == FUNC_FREEL && cnt_q != '0) begin
        do_free = 1'b1; free_slot = loc_f_q ? loc_q : low_q;
      end
    end
    ctl.load  = (state_q == S_DONE) && add_ok;
    ctl.shift = do_free;
    ctl.rot   = scanning;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid && in_ready) begin
        state_d = (in_data_i.func == FUNC_FIND || in_data_i.func == FUNC_FREEM ||
                   in_data_i.func == FUNC_FREEL) ? S_SCAN : S_DONE;
      end
      S_SCAN: if (last) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [15:0] fb;
  logic [16:0] sum;
  always_comb begin
    fb  = loc_f_q ? ent[loc_q].bytes : ent[low_q].bytes;
    if (req_q.func == FUNC_FREEM) fb = ent[ms_q].bytes;
    sum = {1'b0, left_q} + {1'b0, fb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; mem_tot_q <= MEM_RESET; left_q <= MEM_RESET;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) mem_tot_q <= cfg_data_i;
      if (out_valid && out_ready) ov_q <= 1'b0;
      if (state_q == S_DONE) begin
        ov_q <= 1'b1;
        if (ctl.load) begin
          cnt_q <= cnt_q + CW'(1); left_q <= left_q - req_q.state_size;
        end else if (do_free) begin
          cnt_q <= cnt_q - CW'(1); left_q <= sum[16] ? 16'hFFFF : sum[15:0];
        end else if (req_q.func == FUNC_CLEAR) begin
          cnt_q <= '0; left_q <= mem_tot_q;
        end
      end
    end
  end

  // scan accumulators and result
  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      req_q <= in_data_i; idx_q <= '0; mc_q <= '0; ms_q <= '0;
      low_q <= '0; loc_q <= '0; loc_f_q <= 1'b0; lowp_q <= LOCAL_PRIORITY;
    end else if (scanning) begin
      idx_q <= idx_q + (IW + 1)'(1);
      if (in_use) begin
        if (hit) begin mc_q <= mc_q + CW'(1); ms_q <= idx_q[IW-1:0]; end
        if (!loc_f_q && ent[0].retention == LOCAL_PRIORITY) begin
          loc_f_q <= 1'b1; loc_q <= idx_q[IW-1:0];
        end
        if (idx_q == '0 || ent[0].retention < lowp_q) begin
          lowp_q <= ent[0].retention; low_q <= idx_q[IW-1:0];
        end
      end
    end
    if (state_q == S_DONE) begin
      res_q.match_count <= '0; res_q.match_slot <= '0; res_q.status <= ST_OK;
      res_q.memory_left <= left_q;
      unique case (req_q.func)
        FUNC_ADD: begin
          if (cnt_q >= CW'(MAX_STATES)) res_q.status <= ST_FULL;
          else if (req_q.state_size > left_q) res_q.status <= ST_SHORT;
          else begin
            res_q.match_slot <= 4'(cnt_q);
            res_q.memory_left <= left_q - req_q.state_size;
          end
        end
        FUNC_FIND: begin
          res_q.match_count <= 5'(mc_q); res_q.match_slot <= 4'(ms_q);
          if (mc_q == '0) res_q.status <= ST_NONE;
        end
        FUNC_FREEM: begin
          res_q.match_count <= 5'(mc_q);
          if (mc_q == '0) res_q.status <= ST_NONE;
          else if (mc_q != CW'(1)) res_q.status <= ST_AMBIG;
          else begin
            res_q.match_slot <= 4'(ms_q);
            res_q.memory_left <= sum[16] ? 16'hFFFF : sum[15:0];
          end
        end
        FUNC_FREEL: begin
          if (cnt_q == '0) res_q.status <= ST_NONE;
          else begin
            res_q.match_slot <= 4'(free_slot);
            res_q.memory_left <= sum[16] ? 16'hFFFF : sum[15:0];
          end
        end
        FUNC_CLEAR: res_q.memory_left <= mem_tot_q;
        default: res_q.status <= ST_NONE;
      endcase
    end
  end

  assign out_valid  = ov_q;
  assign out_data_o = res_q;

  `PSS_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_STATES), "count over depth")
  `PSS_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready, "taken while busy")
  `PSS_ASSERT_IMP(a_done_out, clk_i, rst_ni, state_q == S_DONE, ##1 ov_q, "result lost")
endmodule

### design/pss_cell.sv
// One storage cell of the entry chain.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_cell
  import pss_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      is_tail_i,   // this cell receives an add
  input  logic      shift_en_i,  // this cell lies at or after the freed slot
  input  entry_t    new_i,
  input  entry_t    next_i,
  output entry_t    ent_o
);
  entry_t ent_q;

  // load, compact or circulate
  always_ff @(posedge clk_i) begin
    if (ctl_i.load && is_tail_i) begin
      ent_q <= new_i;
    end else if (ctl_i.rot || (ctl_i.shift && shift_en_i)) begin
      ent_q <= next_i;
    end
  end

  assign ent_o = ent_q;
endmodule
